@@ rtl/kmmh_pkg.sv @@
// shared types, constants and helper functions for the keyed min-max heap
// no dependencies
package kmmh_pkg;

    localparam int KEY_W   = 8;
    localparam int VAL_W   = 32;
    localparam int IDX_W   = 9;                 // slot index 1..CAPACITY
    localparam int CNT_W   = 9;
    localparam int CAND_W  = 11;                // grandchild index up to 4*CAPACITY+3
    localparam logic [CNT_W-1:0] CAPACITY = 9'd256;

    localparam logic signed [VAL_W-1:0] VAL_TOP = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_BOT = 32'sh8000_0000;

    localparam logic [1:0] MODE_INSERT  = 2'd0;
    localparam logic [1:0] MODE_DEL_MIN = 2'd1;
    localparam logic [1:0] MODE_DEL_MAX = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_BADKEY = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] value;
    } t_entry;

    typedef t_entry [2:0] t_top;                // copies of slots 1..3

    typedef struct packed {
        logic [1:0]              status;
        logic [KEY_W-1:0]        removed_key;
        logic signed [VAL_W-1:0] min_value;
        logic signed [VAL_W-1:0] max_value;
        logic [CNT_W-1:0]        entry_count;
        logic                    is_full;
    } t_result;

    function automatic logic better(input logic signed [VAL_W-1:0] a,
                                    input logic signed [VAL_W-1:0] b,
                                    input logic minside);
        better = minside ? (a < b) : (a > b);
    endfunction

    // root is level 0, even levels are min levels
    function automatic logic on_min_level(input logic [IDX_W-1:0] idx);
        logic [3:0] lv;
        lv = 4'd0;
        for (int b = 1; b < IDX_W; b++) begin
            if (idx[b]) lv = 4'(b);
        end
        on_min_level = ~lv[0];
    endfunction

    // children (sel 0,1) and grandchildren (sel 2..5) of a slot
    function automatic logic [CAND_W-1:0] cand(input logic [IDX_W-1:0] idx,
                                               input logic [2:0] sel);
        logic [CAND_W-1:0] w;
        w = CAND_W'(idx);
        if (sel < 3'd2) cand = (w << 1) + CAND_W'(sel);
        else            cand = (w << 2) + CAND_W'(sel - 3'd2);
    endfunction

endpackage

@@ rtl/kmmh_slot_ram.sv @@
// slot memory of the heap: one write and one registered read per cycle,
// plus copies of slots 1..3 for the min/max report; uses kmmh_pkg
module kmmh_slot_ram (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [kmmh_pkg::IDX_W-1:0] i_widx,
    input  kmmh_pkg::t_entry        i_wdata,
    input  logic                    i_re,
    input  logic [kmmh_pkg::IDX_W-1:0] i_ridx,
    output kmmh_pkg::t_entry        o_rdata,
    output kmmh_pkg::t_top          o_top
);
    import kmmh_pkg::*;

    t_entry r_mem [0:255];
    t_entry r_rdata;
    t_top   r_top;

    logic [7:0] w_waddr;
    logic [7:0] w_raddr;
    logic [IDX_W-1:0] w_wm1;
    logic [IDX_W-1:0] w_rm1;

    assign w_wm1   = i_widx - IDX_W'(1);
    assign w_rm1   = i_ridx - IDX_W'(1);
    assign w_waddr = w_wm1[7:0];
    assign w_raddr = w_rm1[7:0];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[w_waddr] <= i_wdata;
            if (i_widx != '0 && i_widx <= IDX_W'(3)) begin
                r_top[w_wm1[1:0]] <= i_wdata;
            end
        end
        if (i_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_top   = r_top;

endmodule

@@ rtl/kmmh_engine.sv @@
// sequencer for insert and delete: bubble-up and trickle-down over the slot
// memory, key presence bits and entry count; uses kmmh_pkg, kmmh_slot_ram
module kmmh_engine (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [1:0]                 i_mode,
    input  logic [kmmh_pkg::KEY_W-1:0] i_key,
    input  logic signed [kmmh_pkg::VAL_W-1:0] i_value,
    output logic                       o_idle,
    input  logic                       i_res_ready,
    output logic                       o_done,
    output kmmh_pkg::t_result          o_result
);
    import kmmh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_BUB_CHK, S_RISE, S_RISE_CHK, S_PLACE,
        S_DEL_LAST, S_SCAN, S_DECIDE, S_SWAP2, S_FIN
    } t_state;

    t_state           r_state;
    logic [1:0]       r_status;
    logic [KEY_W-1:0] r_rkey;
    t_entry           r_cur;
    logic [IDX_W-1:0] r_i;
    logic             r_mn;
    logic [CNT_W-1:0] r_count;
    logic [255:0]     r_present;
    logic [2:0]       r_j;
    logic             r_pend_v;
    logic [2:0]       r_pend_j;
    logic             r_best_v;
    logic [2:0]       r_best_j;
    t_entry           r_best;
    t_entry           r_ch0;
    t_entry           r_ch1;
    t_entry           r_par;
    logic [IDX_W-1:0] r_swap_idx;

    logic             mem_we;
    logic [IDX_W-1:0] mem_widx;
    t_entry           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_ridx;
    t_entry           mem_rdata;
    t_top             top;

    logic             w_ins_ok;
    logic [IDX_W-1:0] w_new;
    logic [IDX_W-1:0] w_di;
    logic [IDX_W-1:0] w_di_m1;
    logic             w_mn;
    logic [CAND_W-1:0] w_cj;
    logic             w_issue;
    logic [CAND_W-1:0] w_m;
    t_entry           w_par;
    logic             w_best_wins;

    kmmh_slot_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_widx  (mem_widx),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_ridx  (mem_ridx),
        .o_rdata (mem_rdata),
        .o_top   (top)
    );

    always_comb begin
        w_ins_ok = !r_present[i_key] && (r_count != CAPACITY);
        w_new    = r_count + CNT_W'(1);
        if (i_mode == MODE_DEL_MIN) begin
            w_di = IDX_W'(1);
        end else if (r_count >= CNT_W'(3)) begin
            w_di = (top[1].value > top[2].value) ? IDX_W'(2) : IDX_W'(3);
        end else begin
            w_di = r_count;
        end
        w_di_m1     = w_di - IDX_W'(1);
        w_mn        = on_min_level(r_i);
        w_cj        = cand(r_i, r_j);
        w_issue     = (r_j < 3'd6) && (w_cj <= CAND_W'(r_count));
        w_m         = cand(r_i, r_best_j);
        w_par       = (r_best_j < 3'd4) ? r_ch0 : r_ch1;
        w_best_wins = better(r_best.value, r_cur.value, r_mn);
    end

    // memory port control
    always_comb begin
        mem_we    = 1'b0;
        mem_widx  = r_i;
        mem_wdata = r_cur;
        mem_re    = 1'b0;
        mem_ridx  = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_mode == MODE_INSERT) begin
                        mem_re   = w_ins_ok && (w_new != IDX_W'(1));
                        mem_ridx = w_new >> 1;
                    end else if (i_mode == MODE_DEL_MIN || i_mode == MODE_DEL_MAX) begin
                        mem_re   = (r_count != '0);
                        mem_ridx = r_count;
                    end
                end
            end
            S_BUB_CHK: begin
                mem_we    = better(r_cur.value, mem_rdata.value, !w_mn);
                mem_wdata = mem_rdata;
            end
            S_RISE: begin
                mem_re   = (r_i >> 2) != '0;
                mem_ridx = r_i >> 2;
            end
            S_RISE_CHK: begin
                mem_we    = better(r_cur.value, mem_rdata.value, r_mn);
                mem_wdata = mem_rdata;
            end
            S_PLACE: begin
                mem_we = 1'b1;
            end
            S_SCAN: begin
                mem_re   = w_issue;
                mem_ridx = w_cj[IDX_W-1:0];
            end
            S_DECIDE: begin
                mem_we    = r_best_v && w_best_wins;
                mem_wdata = r_best;
            end
            S_SWAP2: begin
                mem_we   = 1'b1;
                mem_widx = r_swap_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_present <= '0;
            r_pend_v  <= 1'b0;
            r_best_v  <= 1'b0;
            r_j       <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_status <= ST_OK;
                        r_rkey   <= '0;
                        if (i_mode == MODE_INSERT) begin
                            if (!w_ins_ok) begin
                                r_status <= ST_BADKEY;
                                r_state  <= S_FIN;
                            end else begin
                                r_count            <= w_new;
                                r_present[i_key]   <= 1'b1;
                                r_cur              <= '{key: i_key, value: i_value};
                                r_i                <= w_new;
                                r_state <= (w_new == IDX_W'(1)) ? S_PLACE : S_BUB_CHK;
                            end
                        end else if (i_mode == MODE_DEL_MIN || i_mode == MODE_DEL_MAX) begin
                            if (r_count == '0) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_FIN;
                            end else begin
                                r_i                           <= w_di;
                                r_rkey                        <= top[w_di_m1[1:0]].key;
                                r_present[top[w_di_m1[1:0]].key] <= 1'b0;
                                r_count                       <= r_count - CNT_W'(1);
                                r_state                       <= S_DEL_LAST;
                            end
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_BUB_CHK: begin
                    if (better(r_cur.value, mem_rdata.value, !w_mn)) begin
                        r_i  <= r_i >> 1;
                        r_mn <= !w_mn;
                    end else begin
                        r_mn <= w_mn;
                    end
                    r_state <= S_RISE;
                end
                S_RISE: begin
                    r_state <= ((r_i >> 2) != '0) ? S_RISE_CHK : S_PLACE;
                end
                S_RISE_CHK: begin
                    if (better(r_cur.value, mem_rdata.value, r_mn)) begin
                        r_i     <= r_i >> 2;
                        r_state <= S_RISE;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: begin
                    r_state <= S_FIN;
                end
                S_DEL_LAST: begin
                    r_cur <= mem_rdata;
                    if (r_i <= r_count) begin
                        r_mn     <= w_mn;
                        r_j      <= '0;
                        r_pend_v <= 1'b0;
                        r_best_v <= 1'b0;
                        r_state  <= S_SCAN;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SCAN: begin
                    // consume the candidate read last cycle
                    if (r_pend_v) begin
                        if (r_pend_j == 3'd0) r_ch0 <= mem_rdata;
                        if (r_pend_j == 3'd1) r_ch1 <= mem_rdata;
                        if (!r_best_v || better(mem_rdata.value, r_best.value, r_mn)) begin
                            r_best   <= mem_rdata;
                            r_best_j <= r_pend_j;
                            r_best_v <= 1'b1;
                        end
                    end
                    // issue the next one; indices ascend so stop at the first miss
                    if (w_issue) begin
                        r_pend_v <= 1'b1;
                        r_pend_j <= r_j;
                        r_j      <= r_j + 3'd1;
                    end else begin
                        r_pend_v <= 1'b0;
                        r_j      <= 3'd6;
                        if (!r_pend_v) r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (!r_best_v || !w_best_wins) begin
                        r_state <= S_PLACE;
                    end else if (r_best_j >= 3'd2) begin
                        r_i      <= w_m[IDX_W-1:0];
                        r_j      <= '0;
                        r_pend_v <= 1'b0;
                        r_best_v <= 1'b0;
                        if (better(w_par.value, r_cur.value, r_mn)) begin
                            r_swap_idx <= w_m[IDX_W:1];
                            r_par      <= w_par;
                            r_state    <= S_SWAP2;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end else begin
                        r_i     <= w_m[IDX_W-1:0];
                        r_state <= S_PLACE;
                    end
                end
                S_SWAP2: begin
                    r_cur   <= r_par;
                    r_state <= S_SCAN;
                end
                S_FIN: begin
                    if (i_res_ready) r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_result.status      = r_status;
        o_result.removed_key = r_rkey;
        o_result.entry_count = r_count;
        o_result.is_full     = (r_count == CAPACITY);
        o_result.min_value   = VAL_TOP;
        o_result.max_value   = VAL_BOT;
        if (r_count != '0) begin
            o_result.min_value = top[0].value;
            if (r_count > CNT_W'(2)) begin
                o_result.max_value = (top[1].value > top[2].value) ?
                                     top[1].value : top[2].value;
            end else if (r_count == CNT_W'(2)) begin
                o_result.max_value = top[1].value;
            end else begin
                o_result.max_value = top[0].value;
            end
        end
    end

    assign o_idle = (r_state == S_IDLE);
    assign o_done = (r_state == S_FIN) && i_res_ready;

endmodule

@@ rtl/keyed_min_max_heap.sv @@
// top level of the keyed min-max heap: stream ports and result register
// depends on kmmh_pkg and kmmh_engine
//
// usage
//   one command per slave-side transfer: insert a (key, value) pair, or
//   delete the minimum or the maximum entry
//   each command gives exactly one master-side transfer carrying status,
//   removed key, current minimum and maximum, entry count and full flag
//   commands are handled one at a time; s_tready is high only while the
//   sequencer is idle
//   a rejected or empty-heap command goes straight to the result register;
//   an insert into an empty heap writes slot 1 directly, any other insert
//   compares with its parent, then climbs by grandparents; a delete moves
//   the last entry into the hole and trickles it down, reading its children
//   and grandchildren with one registered read of the slot memory per cycle
//   the result sits in an output register, so the next command is taken
//   while a finished result still waits; a stalled receiver holds the
//   sequencer only once a second result is ready
//   reset clears the entry count, the key presence bits and the output
//   valid; slot contents need no clearing since only held slots are read
module keyed_min_max_heap (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // mode[1:0], key[9:2], value[41:10], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata    // status[1:0], removed_key[9:2], min_value[41:10],
                                   // max_value[73:42], entry_count[82:74], is_full[83]
);
    import kmmh_pkg::*;

    logic    w_start;
    logic    w_idle;
    logic    w_res_ready;
    logic    w_done;
    t_result w_result;

    logic        r_m_valid;
    logic [87:0] r_m_data;

    assign s_tready    = w_idle;
    assign w_start     = s_tvalid && w_idle;
    // result register is free when empty or being drained this cycle
    assign w_res_ready = !r_m_valid || m_tready;

    kmmh_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_mode      (s_tdata[1:0]),
        .i_key       (s_tdata[9:2]),
        .i_value     (s_tdata[41:10]),
        .o_idle      (w_idle),
        .i_res_ready (w_res_ready),
        .o_done      (w_done),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            if (w_done) begin
                r_m_valid <= 1'b1;
                r_m_data  <= {4'd0, w_result.is_full, w_result.entry_count,
                              w_result.max_value, w_result.min_value,
                              w_result.removed_key, w_result.status};
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    // count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[82:74] <= CAPACITY))
        else $error("entry count beyond capacity");

    // an empty-heap report comes only with no entries held
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[1:0] == ST_EMPTY) |-> (m_tdata[82:74] == '0))
        else $error("empty status with entries held");

    // failed commands remove nothing
    a_fail_nokey: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tdata[1:0] != ST_OK) |-> (m_tdata[9:2] == '0))
        else $error("removed key on failed command");

endmodule

@@ dv/tb.sv @@
// testbench for the keyed min-max heap: drives commands over the stream input,
// predicts each result with a behavioral heap and compares every field
// depends on kmmh_pkg and keyed_min_max_heap
module tb;
    import kmmh_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // mode[1:0], key[9:2], value[41:10], zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // status, removed_key, min_value, max_value, entry_count, is_full

    keyed_min_max_heap dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int NUM_KEYS = 256;

    typedef struct {
        logic [1:0]              status;
        logic [KEY_W-1:0]        removed_key;
        logic signed [VAL_W-1:0] min_value;
        logic signed [VAL_W-1:0] max_value;
        logic [CNT_W-1:0]        entry_count;
        logic                    is_full;
    } t_heap_result;

    // behavioral heap, slots 1..heap_count
    logic [KEY_W-1:0]        heap_key [1:NUM_KEYS];
    logic signed [VAL_W-1:0] heap_val [1:NUM_KEYS];
    bit                      key_used [NUM_KEYS];
    int                      heap_count;

    t_heap_result expected_results[$];
    int  fail_count;
    int  idle_cycles;
    int  send_idle_pct;
    int  recv_idle_pct;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit level_is_min(int i);
        int lv;
        lv = 0;
        while (i > 1) begin
            i = i >> 1;
            lv++;
        end
        return (lv % 2) == 0;
    endfunction

    function automatic bit beats(logic signed [VAL_W-1:0] a, logic signed [VAL_W-1:0] b,
                                 bit minside);
        return minside ? (a < b) : (a > b);
    endfunction

    function automatic void swap_slots(int a, int b);
        logic [KEY_W-1:0]        k;
        logic signed [VAL_W-1:0] v;
        k = heap_key[a]; v = heap_val[a];
        heap_key[a] = heap_key[b]; heap_val[a] = heap_val[b];
        heap_key[b] = k; heap_val[b] = v;
    endfunction

    function automatic void climb_grand(int i, bit minside);
        while (i / 4 > 0 && beats(heap_val[i], heap_val[i / 4], minside)) begin
            swap_slots(i, i / 4);
            i = i / 4;
        end
    endfunction

    function automatic void sift_up(int i);
        bit mn;
        if (i / 2 == 0) return;
        mn = level_is_min(i);
        if (beats(heap_val[i], heap_val[i / 2], !mn)) begin
            swap_slots(i, i / 2);
            climb_grand(i / 2, !mn);
        end else begin
            climb_grand(i, mn);
        end
    endfunction

    function automatic int best_descendant(int i, bit minside);
        int c[6];
        int m;
        m = 0;
        c[0] = 2 * i; c[1] = 2 * i + 1;
        c[2] = 4 * i; c[3] = 4 * i + 1; c[4] = 4 * i + 2; c[5] = 4 * i + 3;
        if (c[0] <= heap_count) m = c[0];
        for (int j = 1; j < 6; j++)
            if (c[j] <= heap_count && beats(heap_val[c[j]], heap_val[m], minside))
                m = c[j];
        return m;
    endfunction

    function automatic void sift_down(int i);
        bit mn;
        int m;
        mn = level_is_min(i);
        forever begin
            m = best_descendant(i, mn);
            if (m == 0) return;
            if (m > 2 * i + 1) begin
                if (!beats(heap_val[m], heap_val[i], mn)) return;
                swap_slots(i, m);
                if (beats(heap_val[m / 2], heap_val[m], mn)) swap_slots(m, m / 2);
                i = m;
            end else begin
                if (beats(heap_val[m], heap_val[i], mn)) swap_slots(i, m);
                return;
            end
        end
    endfunction

    // applies one command to the behavioral heap and queues the result it gives
    function automatic void predict_heap_step(logic [1:0] mode, logic [KEY_W-1:0] key,
                                              logic signed [VAL_W-1:0] value);
        t_heap_result r;
        int i;
        r.status = ST_OK;
        r.removed_key = '0;
        if (mode == MODE_INSERT) begin
            if (key_used[key] || heap_count >= NUM_KEYS) begin
                r.status = ST_BADKEY;
            end else begin
                heap_count++;
                heap_key[heap_count] = key;
                heap_val[heap_count] = value;
                key_used[key] = 1'b1;
                sift_up(heap_count);
            end
        end else if (mode == MODE_DEL_MIN || mode == MODE_DEL_MAX) begin
            if (heap_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                i = 1;
                if (mode == MODE_DEL_MAX) begin
                    if (heap_count >= 3) i = (heap_val[2] > heap_val[3]) ? 2 : 3;
                    else i = heap_count;
                end
                r.removed_key = heap_key[i];
                key_used[heap_key[i]] = 1'b0;
                heap_key[i] = heap_key[heap_count];
                heap_val[i] = heap_val[heap_count];
                heap_count--;
                if (i <= heap_count) sift_down(i);
            end
        end
        r.min_value = VAL_TOP;
        r.max_value = VAL_BOT;
        if (heap_count > 0) begin
            r.min_value = heap_val[1];
            if (heap_count > 2)
                r.max_value = (heap_val[2] > heap_val[3]) ? heap_val[2] : heap_val[3];
            else
                r.max_value = heap_val[heap_count];
        end
        r.entry_count = CNT_W'(heap_count);
        r.is_full = (heap_count == NUM_KEYS);
        expected_results.push_back(r);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("tb: mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    // one command transfer, with random idle cycles before it
    task automatic send_command(logic [1:0] mode, logic [KEY_W-1:0] key,
                                logic signed [VAL_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, value, key, mode};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_heap_step(mode, key, value);
    endtask

    // receiver stalls and result checking
    always @(posedge i_clk) begin
        if (i_rst_n) m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_heap_result e;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $display("tb: unexpected result at %0t", $time);
                fail_count++;
            end else begin
                e = expected_results.pop_front();
                if (m_tdata[1:0] !== e.status)
                    report_mismatch("status", m_tdata[1:0], e.status);
                if (m_tdata[9:2] !== e.removed_key)
                    report_mismatch("removed_key", m_tdata[9:2], e.removed_key);
                if (m_tdata[41:10] !== e.min_value)
                    report_mismatch("min_value", m_tdata[41:10], e.min_value);
                if (m_tdata[73:42] !== e.max_value)
                    report_mismatch("max_value", m_tdata[73:42], e.max_value);
                if (m_tdata[82:74] !== e.entry_count)
                    report_mismatch("entry_count", m_tdata[82:74], e.entry_count);
                if (m_tdata[83] !== e.is_full)
                    report_mismatch("is_full", m_tdata[83], e.is_full);
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic logic signed [VAL_W-1:0] random_value();
        case ($urandom_range(5))
            0: return VAL_TOP;
            1: return VAL_BOT;
            2: return VAL_W'($urandom_range(7)) - 3;   // many ties
            default: return $urandom;
        endcase
    endfunction

    // extremes, empty deletes, duplicates, unused mode, delete-max tie
    task automatic test_directed();
        send_command(MODE_DEL_MIN, 8'd0, 0);
        send_command(MODE_DEL_MAX, 8'd0, 0);
        send_command(MODE_INSERT, 8'd0, VAL_BOT);
        send_command(MODE_INSERT, 8'd255, VAL_TOP);
        send_command(MODE_INSERT, 8'd255, 32'sd5);
        send_command(MODE_INSERT, 8'hAA, 32'sd7);
        send_command(MODE_INSERT, 8'h55, 32'sd7);
        send_command(2'd3, 8'hFF, -1);
        send_command(MODE_DEL_MAX, 8'd0, 0);
        send_command(MODE_DEL_MAX, 8'd0, 0);
        send_command(MODE_DEL_MAX, 8'd0, 0);
        send_command(MODE_DEL_MIN, 8'd0, 0);
        send_command(MODE_INSERT, 8'd1, 32'sd3);
        send_command(MODE_INSERT, 8'd2, 32'sd9);
        send_command(MODE_INSERT, 8'd3, 32'sd9);
        send_command(MODE_DEL_MAX, 8'd0, 0);
        send_command(MODE_DEL_MIN, 8'd0, 0);
        send_command(MODE_DEL_MIN, 8'd0, 0);
        send_command(MODE_DEL_MIN, 8'd0, 0);
    endtask

    // fill to capacity, an overflow attempt, then drain
    task automatic test_full_heap();
        for (int k = 0; k < NUM_KEYS; k++)
            send_command(MODE_INSERT, KEY_W'(k), random_value());
        send_command(MODE_INSERT, 8'd17, 0);
        for (int k = 0; k < NUM_KEYS + 1; k++)
            send_command($urandom_range(1) ? MODE_DEL_MAX : MODE_DEL_MIN, 8'd0, 0);
    endtask

    // random mix biased toward inserts of free keys to reach deep levels
    task automatic test_random_mix(int n);
        logic [1:0]       mode;
        logic [KEY_W-1:0] key;
        int               pick;
        for (int t = 0; t < n; t++) begin
            pick = $urandom_range(99);
            key = KEY_W'($urandom);
            if (pick < 55) begin
                mode = MODE_INSERT;
                for (int tries = 0; tries < 8 && key_used[key]; tries++)
                    key = KEY_W'($urandom);
            end else if (pick < 75) mode = MODE_DEL_MIN;
            else if (pick < 95) mode = MODE_DEL_MAX;
            else if (pick < 98) mode = MODE_INSERT;
            else mode = 2'd3;
            send_command(mode, key, random_value());
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        heap_count = 0;
        fail_count = 0;
        idle_cycles = 0;
        send_idle_pct = 35;
        recv_idle_pct = 51;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_heap();
        test_random_mix(90);
        send_idle_pct = 51;
        recv_idle_pct = 35;
        test_random_mix(90);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(90);
        drain_results();

        if (fail_count == 0) $display("tb: PASS");
        else $display("tb: FAIL");
        $finish;
    end

endmodule
